### rtl/core/sfcd_pkg.sv
// Shared types and constants of the serial channel frame decoder.
package sfcd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int CHAN_W        = 11;
  localparam int FRAME_BITS    = CHANNEL_COUNT * CHAN_W;
  localparam int COUNT_W       = 5;
  localparam int INDEX_W       = 4;

  // Byte positions within a frame, and the index of the last channel
  localparam logic [COUNT_W-1:0] LAST_DATA_POS = COUNT_W'(FRAME_BITS / 8);
  localparam logic [COUNT_W-1:0] FOOTER_POS    = COUNT_W'(FRAME_BYTES - 1);
  localparam logic [INDEX_W-1:0] LAST_CHANNEL  = INDEX_W'(CHANNEL_COUNT - 1);

  localparam logic [7:0] HEADER_RESET = 8'h0F;
  localparam logic [7:0] FOOTER_RESET = 8'h00;

  typedef enum logic [0:0] {
    REG_HEADER = 1'b0,
    REG_FOOTER = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       we;
    reg_index_t index;
    logic [7:0] data;
  } cfg_wr_t;

  typedef logic [FRAME_BITS-1:0] frame_bits_t;

endpackage

### rtl/core/sfcd_if.sv
// Stream interfaces for received bytes and decoded channels.
interface sfcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcd_chan_if;
  logic                         valid;
  logic                         ready;
  logic [sfcd_pkg::INDEX_W-1:0] channel_index;
  logic [sfcd_pkg::CHAN_W-1:0]  channel_value;
  logic                         last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input last_channel, output ready);
endinterface

### rtl/core/sfcd_front.sv
// Byte collector: header hunt, frame assembly and footer check.
module sfcd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  sfcd_pkg::cfg_wr_t     cfg,
  sfcd_byte_if.sink             rx,
  input  logic                  q_full,
  output logic                  push,
  output sfcd_pkg::frame_bits_t frame
);
  import sfcd_pkg::*;

  logic [7:0]         header_value;
  logic [7:0]         footer_value;
  logic               in_frame;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         first_byte;
  logic               accept;
  logic               at_footer;

  assign at_footer = in_frame && (byte_count == FOOTER_POS);
  // Stall only on the closing byte when the queue has no room
  assign rx.ready  = !(at_footer && q_full);
  assign accept    = rx.valid && rx.ready;
  assign push      = accept && at_footer && (first_byte == header_value) &&
                     (rx.rx_byte == footer_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      footer_value <= FOOTER_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_HEADER: header_value <= cfg.data;
        REG_FOOTER: footer_value <= cfg.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx.rx_byte == header_value) begin
          in_frame   <= 1'b1;
          byte_count <= COUNT_W'(1);
        end
      end else if (at_footer) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + COUNT_W'(1);
      end
    end
  end

  // Shift data bytes in from the top so byte 1 ends at bit 0
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!in_frame) begin
        first_byte <= rx.rx_byte;
      end else if (byte_count <= LAST_DATA_POS) begin
        frame <= {rx.rx_byte, frame[FRAME_BITS-1:8]};
      end
    end
  end

endmodule

### rtl/core/sfcd_queue.sv
// Two-entry frame queue between the collector and the channel emitter.
module sfcd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sfcd_pkg::frame_bits_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output sfcd_pkg::frame_bits_t pop_data
);
  import sfcd_pkg::*;

  frame_bits_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

### rtl/core/sfcd_back.sv
// Channel emitter: unpacks one frame into sixteen channel items.
module sfcd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  sfcd_pkg::frame_bits_t frame,
  output logic                  pop,
  sfcd_chan_if.source           ch
);
  import sfcd_pkg::*;

  logic               busy;
  logic [INDEX_W-1:0] index;
  frame_bits_t        bits;
  logic               take;
  logic               done;

  assign take = ch.valid && ch.ready;
  assign done = take && (index == LAST_CHANNEL);
  assign pop  = not_empty && (!busy || done);

  assign ch.valid         = busy;
  assign ch.channel_index = index;
  assign ch.channel_value = bits[CHAN_W-1:0];
  assign ch.last_channel  = (index == LAST_CHANNEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      index <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      index <= '0;
    end else if (done) begin
      busy  <= 1'b0;
      index <= '0;
    end else if (take) begin
      index <= index + INDEX_W'(1);
    end
  end

  // Advance to the next channel by dropping the low field
  always_ff @(posedge clk) begin
    if (pop) begin
      bits <= frame;
    end else if (take) begin
      bits <= {{CHAN_W{1'b0}}, bits[FRAME_BITS-1:CHAN_W]};
    end
  end

endmodule

### rtl/core/sbus_frame_channel_decoder_top.sv
// Top level: frame collector, frame queue and channel emitter.
// Accepts one byte per cycle; ready drops only on a closing byte while two
// decoded frames are still queued. A good frame's first channel becomes valid once
// the emitter has popped it from the queue; its sixteen channels then leave at
// one per cycle while ch.ready is high, set by the shift register and handshake.
// Synchronous reset hunts for a header, empties the queue, restores registers.
module sbus_frame_channel_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  sfcd_byte_if.sink  rx,
  sfcd_chan_if.source ch
);
  import sfcd_pkg::*;

  cfg_wr_t     cfg;
  logic        push;
  logic        q_full;
  logic        pop;
  logic        not_empty;
  frame_bits_t front_frame;
  frame_bits_t queue_frame;

  assign cfg.we    = cfg_we;
  assign cfg.index = reg_index_t'(cfg_index);
  assign cfg.data  = cfg_data;

  sfcd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .rx     (rx),
    .q_full (q_full),
    .push   (push),
    .frame  (front_frame)
  );

  sfcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_frame),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (queue_frame)
  );

  sfcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .frame     (queue_frame),
    .pop       (pop),
    .ch        (ch)
  );

endmodule

### tb/tb_sbus_frame_channel_decoder_top.sv
// Self-checking testbench for the serial frame channel decoder: byte stimulus, frame predictor.
`timescale 1ns / 100ps

class channel_scoreboard;
  typedef struct {
    logic [sfcd_pkg::INDEX_W-1:0] index;
    logic [sfcd_pkg::CHAN_W-1:0]  value;
    logic                         last;
  } channel_t;

  logic [7:0] header_reg;
  logic [7:0] footer_reg;
  bit         in_frame;
  int         byte_count;
  logic [7:0] frame_store [sfcd_pkg::FRAME_BYTES];
  channel_t   due_channels [$];
  int         errors;

  function new();
    header_reg = sfcd_pkg::HEADER_RESET;
    footer_reg = sfcd_pkg::FOOTER_RESET;
    in_frame   = 1'b0;
    byte_count = 0;
    errors     = 0;
    foreach (frame_store[i]) frame_store[i] = 8'h00;
  endfunction

  function int pending();
    return due_channels.size();
  endfunction

  function void set_reg(sfcd_pkg::reg_index_t idx, logic [7:0] data);
    case (idx)
      sfcd_pkg::REG_HEADER: header_reg = data;
      sfcd_pkg::REG_FOOTER: footer_reg = data;
      default: ;
    endcase
  endfunction

  // Unpack the data bytes into one little-endian bit stream, then slice channels.
  function void unpack_frame();
    sfcd_pkg::frame_bits_t bits;
    channel_t              c;
    for (int i = 0; i < sfcd_pkg::FRAME_BITS / 8; i++) bits[8*i +: 8] = frame_store[i + 1];
    for (int k = 0; k < sfcd_pkg::CHANNEL_COUNT; k++) begin
      c.index = k[sfcd_pkg::INDEX_W-1:0];
      c.value = bits[sfcd_pkg::CHAN_W*k +: sfcd_pkg::CHAN_W];
      c.last  = (c.index == sfcd_pkg::LAST_CHANNEL);
      due_channels.push_back(c);
    end
  endfunction

  function void note_byte(logic [7:0] b);
    if (!in_frame) begin
      if (b == header_reg) begin
        frame_store[0] = b;
        byte_count     = 1;
        in_frame       = 1'b1;
      end
      return;
    end
    frame_store[byte_count] = b;
    byte_count++;
    if (byte_count == sfcd_pkg::FRAME_BYTES) begin
      // Drop on a bad footer or on a header that no longer matches.
      if (frame_store[0] == header_reg &&
          frame_store[sfcd_pkg::FRAME_BYTES-1] == footer_reg) unpack_frame();
      in_frame   = 1'b0;
      byte_count = 0;
    end
  endfunction

  task report(string msg);
    if (errors < 50) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_channel(logic [sfcd_pkg::INDEX_W-1:0] index, logic [sfcd_pkg::CHAN_W-1:0] value,
                     logic last);
    channel_t want;
    if (due_channels.size() == 0) begin
      report($sformatf("unexpected channel %0d value %0d", index, value));
      return;
    end
    want = due_channels.pop_front();
    if (index !== want.index)
      report($sformatf("channel_index %0d, want %0d", index, want.index));
    if (value !== want.value)
      report($sformatf("channel %0d value %0d, want %0d", want.index, value, want.value));
    if (last !== want.last)
      report($sformatf("channel %0d last_channel %0b, want %0b", want.index, last, want.last));
  endtask
endclass

module tb_sbus_frame_channel_decoder_top;
  localparam int ITEM_TARGET  = 350;
  localparam int PHASES       = 8;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  sfcd_byte_if byte_bus ();
  sfcd_chan_if chan_bus ();

  sbus_frame_channel_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (byte_bus.sink),
    .ch        (chan_bus.source)
  );

  channel_scoreboard frame_board;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                idle_cycles;
  int                frame_items;
  logic [7:0]        header_val;
  logic [7:0]        footer_val;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver side: stall at random.
  always @(posedge clk) begin
    chan_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Track accepted items and configuration writes; watch for a hang.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_we) frame_board.set_reg(sfcd_pkg::reg_index_t'(cfg_index), cfg_data);
      if (byte_bus.valid && byte_bus.ready) frame_board.note_byte(byte_bus.rx_byte);
      if (chan_bus.valid && chan_bus.ready)
        frame_board.check_channel(chan_bus.channel_index, chan_bus.channel_value,
                                  chan_bus.last_channel);
      if ((byte_bus.valid && byte_bus.ready) || (chan_bus.valid && chan_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= b;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    frame_items++;
  endtask

  // Drop valid, let every queued channel drain, then let the pipeline settle.
  task wait_drained();
    byte_bus.valid <= 1'b0;
    @(posedge clk);
    while (frame_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_regs(input logic [7:0] hdr, input logic [7:0] ftr);
    cfg_we    <= 1'b1;
    cfg_index <= sfcd_pkg::REG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    cfg_index <= sfcd_pkg::REG_FOOTER;
    cfg_data  <= ftr;
    @(posedge clk);
    cfg_we     <= 1'b0;
    header_val  = hdr;
    footer_val  = ftr;
  endtask

  task send_fixed_frame(input logic [7:0] fill, input logic [7:0] ftr);
    send_byte(header_val);
    for (int i = 1; i < sfcd_pkg::FRAME_BYTES - 1; i++) send_byte(fill);
    send_byte(ftr);
  endtask

  task send_random_frame(input bit good_footer);
    logic [7:0] b;
    send_byte(header_val);
    for (int i = 1; i < sfcd_pkg::FRAME_BYTES - 1; i++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = header_val;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b);
    end
    if (good_footer) send_byte(footer_val);
    else             send_byte(footer_val ^ (8'h01 << $urandom_range(7)));
  endtask

  task set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  initial begin
    int         r;
    logic [7:0] hdr;
    logic [7:0] ftr;
    frame_board      = new();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = sfcd_pkg::REG_HEADER;
    cfg_data         = 8'h00;
    byte_bus.valid   = 1'b0;
    byte_bus.rx_byte = 8'h00;
    frame_items = 0;
    header_val  = sfcd_pkg::HEADER_RESET;
    footer_val  = sfcd_pkg::FOOTER_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored bytes while hunting, extreme channel values, header as data.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(header_val ^ 8'h01);
    send_fixed_frame(8'hFF, footer_val);
    send_fixed_frame(8'h00, footer_val);
    send_fixed_frame(header_val, footer_val);
    // Bad footer: no channels.
    send_fixed_frame(8'h55, footer_val ^ 8'h80);
    // Header rewritten halfway through a frame: the frame is dropped.
    send_byte(header_val);
    for (int i = 1; i < 12; i++) send_byte(8'hAA);
    wait_drained();
    write_regs(8'hA5, footer_val);
    for (int i = 12; i < sfcd_pkg::FRAME_BYTES - 1; i++) send_byte(8'hAA);
    send_byte(footer_val);
    send_fixed_frame(8'h5A, footer_val);

    // Random frames over several register settings and idling patterns.
    frame_items = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       begin hdr = sfcd_pkg::HEADER_RESET; ftr = sfcd_pkg::FOOTER_RESET; end
        1:       begin hdr = 8'hFF; ftr = 8'hFF; end
        2:       begin hdr = 8'h00; ftr = 8'hFF; end
        3:       begin hdr = 8'hFF; ftr = 8'h00; end
        default: begin hdr = 8'($urandom_range(255)); ftr = 8'($urandom_range(255)); end
      endcase
      write_regs(hdr, ftr);
      set_idling(phase % 4);
      while (frame_items < (phase + 1) * ITEM_TARGET / PHASES) begin
        r = $urandom_range(99);
        if (r < 72) begin
          send_random_frame(1'b1);
        end else if (r < 86) begin
          send_random_frame(1'b0);
        end else begin
          // Noise between frames; a stray header byte starts a frame of its own.
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (frame_board.errors == 0 && frame_board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
